// ----- rtl/cdb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared constants, command and status codes, and cell control for the
// circular deque buffer.
// ----------------------------------------------------------------------------
package cdb_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CMD_W  = 3;
  localparam int STS_W  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // shift_r: each cell takes its front-side neighbor, cell 0 the pushed value (push front)
  // shift_l: each cell takes its rear-side neighbor, the last cell holds (pop front)
  typedef struct packed {
    logic shift_r;
    logic shift_l;
  } cell_ctl_t;

endpackage : cdb_pkg
`default_nettype wire

// ----- rtl/cdb_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdb_cell
// One deque entry. Loads the pushed value, takes a neighbor's entry on a
// shift, or holds.
// ----------------------------------------------------------------------------
module cdb_cell (
  input  wire logic                      clk,
  input  wire cdb_pkg::cell_ctl_t        ctl,
  input  wire logic                      load,
  input  wire logic [cdb_pkg::DATA_W-1:0] push_data,
  input  wire logic [cdb_pkg::DATA_W-1:0] left_data,
  input  wire logic [cdb_pkg::DATA_W-1:0] right_data,
  output logic      [cdb_pkg::DATA_W-1:0] data_q
);
  import cdb_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = push_data;
    end else if (ctl.shift_r) begin
      data_nxt = left_data;
    end else if (ctl.shift_l) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule : cdb_cell
`default_nettype wire

// ----- rtl/circular_deque_buffer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Output register: result valid in the cycle after the command transfer.
// Throughput: 1 command per cycle while the receiver does not stall; the
//   occupancy count and the cell row update in the transfer cycle, and the
//   output register frees on the same edge its result is taken.
// Reset: occupancy and output valid clear, capacity returns to DEPTH; cell
//   contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
// circular_deque_buffer_unit
// Double-ended queue held as a row of cells ordered front to rear; push and
// pop at the front shift the row, rear operations index cells by occupancy.
// ----------------------------------------------------------------------------
module circular_deque_buffer_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [cdb_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic signed [cdb_pkg::DATA_W-1:0] in_push_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [cdb_pkg::DATA_W-1:0] out_read_value,
  output logic      [cdb_pkg::STS_W-1:0]  out_status,
  output logic                            out_empty_now,
  output logic                            out_full_now,
  input  wire logic                       cfg_wr_en,
  input  wire logic [cdb_pkg::CFG_W-1:0]  cfg_wr_data
);
  import cdb_pkg::*;

  logic [CFG_W-1:0]  cap_cfg_r;
  logic [CNT_W-1:0]  occ_r;
  logic [CNT_W-1:0]  occ_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] read_value_r;
  status_t           status_r;
  logic              empty_now_r;
  logic              full_now_r;

  logic [CAP_W-1:0]  cap;
  logic [CAP_W-1:0]  occ_ext;
  logic [CAP_W-1:0]  occ_nxt_ext;
  logic [CNT_W-1:0]  occ_m1;
  logic [IDX_W-1:0]  rear_idx;
  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic              push_rear_go;
  cell_ctl_t         ctl;
  logic [DATA_W-1:0] rv;
  status_t           st;
  logic [DATA_W-1:0] cell_q [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (CAP_W'(cap_cfg_r) < CAP_W'(2)) begin
      cap = CAP_W'(2);
    end else if (CAP_W'(cap_cfg_r) > CAP_W'(DEPTH)) begin
      cap = CAP_W'(DEPTH);
    end else begin
      cap = CAP_W'(cap_cfg_r);
    end
  end

  assign occ_ext  = CAP_W'(occ_r);
  assign is_full  = (occ_ext >= cap);
  assign is_empty = (occ_r == '0);
  assign occ_m1   = occ_r - CNT_W'(1);
  assign rear_idx = occ_m1[IDX_W-1:0];

  always_comb begin
    rv           = '1;
    st           = ST_DONE;
    occ_nxt      = occ_r;
    ctl          = '0;
    push_rear_go = 1'b0;
    case (cmd_t'(in_cmd))
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          st = ST_FULL;
        end else begin
          ctl.shift_r = accept;
          occ_nxt     = occ_r + CNT_W'(1);
        end
      end
      CMD_PUSH_REAR: begin
        if (is_full) begin
          st = ST_FULL;
        end else begin
          push_rear_go = accept;
          occ_nxt      = occ_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else begin
          rv          = cell_q[0];
          ctl.shift_l = accept;
          occ_nxt     = occ_m1;
        end
      end
      CMD_POP_REAR: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else begin
          rv      = cell_q[rear_idx];
          occ_nxt = occ_m1;
        end
      end
      CMD_PEEK_FRONT: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else begin
          rv = cell_q[0];
        end
      end
      CMD_PEEK_REAR: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else begin
          rv = cell_q[rear_idx];
        end
      end
      default: begin
        rv = '1;
        st = ST_DONE;
      end
    endcase
  end

  assign occ_nxt_ext = CAP_W'(occ_nxt);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      logic              load;
      if (gi == 0) begin : g_first
        assign left_d = in_push_value;
      end else begin : g_mid_l
        assign left_d = cell_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_d = cell_q[gi];
      end else begin : g_mid_r
        assign right_d = cell_q[gi+1];
      end
      assign load = push_rear_go && (occ_r == CNT_W'(gi));
      cdb_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .load       (load),
        .push_data  (in_push_value),
        .left_data  (left_d),
        .right_data (right_d),
        .data_q     (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r   <= CFG_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_cfg_r <= cfg_wr_data;
        occ_r     <= '0;
      end else if (accept) begin
        occ_r <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value_r <= rv;
      status_r     <= st;
      empty_now_r  <= (occ_nxt == '0);
      full_now_r   <= (occ_nxt_ext == cap);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = read_value_r;
  assign out_status     = status_r;
  assign out_empty_now  = empty_now_r;
  assign out_full_now   = full_now_r;

endmodule : circular_deque_buffer_unit
`default_nettype wire

// ----- rtl/cdb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdb_checker
// Port-level checks on the deque results, bound to the top level.
// ----------------------------------------------------------------------------
module cdb_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic signed [cdb_pkg::DATA_W-1:0] out_read_value,
  input wire logic [cdb_pkg::STS_W-1:0]   out_status,
  input wire logic                        out_empty_now,
  input wire logic                        out_full_now
);
  import cdb_pkg::*;

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_full_now && out_read_value == '1))
    else $error("full refusal without full flag");

  a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_empty_now && out_read_value == '1))
    else $error("empty refusal without empty flag");

  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_empty_now && out_full_now))
    else $error("empty and full at once");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_EMPTY ||
                   out_status == ST_FULL))
    else $error("undefined status code");

endmodule : cdb_checker

bind circular_deque_buffer_unit cdb_checker u_cdb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_read_value (out_read_value),
  .out_status     (out_status),
  .out_empty_now  (out_empty_now),
  .out_full_now   (out_full_now)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: circular deque buffer unit
// Self-checking bench. A behavioral deque with its own copy of the capacity,
// ring, head, tail and fill count predicts every result. Directed checks
// cover empty and full refusal, clamped capacities, wrap at both ends and
// unused command codes. Random traffic then runs across many capacities with
// bursty input, receiver stalls and push/pop bias that swings between full
// and empty.
// ----------------------------------------------------------------------------
module tb;
  import cdb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    status_t                  status;
    logic                     empty_now;
    logic                     full_now;
  } deque_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_cmd = CMD_PUSH_FRONT;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_read_value;
  logic [STS_W-1:0]         out_status;
  logic                     out_empty_now;
  logic                     out_full_now;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]         cfg_wr_data = '0;

  // predicted deque
  logic [CFG_W-1:0]  cap_reg;
  logic [DATA_W-1:0] ring_model [DEPTH];
  int                front_idx;
  int                rear_idx;
  int                fill_count;

  deque_result_t pending_results[$];
  int            mismatches = 0;

  // idling controls
  int  stall_mode = 0;
  int  stall_run = 0;
  bit  sender_gaps = 1'b0;
  int  burst_left = 0;

  circular_deque_buffer_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_empty_now (out_empty_now),
    .out_full_now  (out_full_now),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic deque_result_t deque_step(input logic [CMD_W-1:0] cmd,
                                               input logic [DATA_W-1:0] val);
    deque_result_t r;
    int            lim;
    int            pick;
    lim = (cap_reg < 2) ? 2 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
    r.read_value = '1;
    r.status = ST_DONE;
    if (fill_count > lim) fill_count = lim;
    if (front_idx >= lim) front_idx = 0;
    if (rear_idx >= lim) rear_idx = 0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (fill_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          if (fill_count == 0) begin
            front_idx = 0;
            rear_idx = 0;
            ring_model[0] = val;
          end else if (cmd == CMD_PUSH_FRONT) begin
            front_idx = (front_idx == 0) ? lim - 1 : front_idx - 1;
            ring_model[front_idx] = val;
          end else begin
            rear_idx = (rear_idx == lim - 1) ? 0 : rear_idx + 1;
            ring_model[rear_idx] = val;
          end
          fill_count++;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
        if (fill_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pick = (cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT) ? front_idx : rear_idx;
          r.read_value = ring_model[pick];
          if (cmd == CMD_POP_FRONT || cmd == CMD_POP_REAR) begin
            if (fill_count == 1) begin
              front_idx = 0;
              rear_idx = 0;
            end else if (cmd == CMD_POP_FRONT) begin
              front_idx = (front_idx == lim - 1) ? 0 : front_idx + 1;
            end else begin
              rear_idx = (rear_idx == 0) ? lim - 1 : rear_idx - 1;
            end
            fill_count--;
          end
        end
      end
      default: begin
      end
    endcase
    r.empty_now = (fill_count == 0);
    r.full_now = (fill_count == lim);
    return r;
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_run == 0) begin
          out_stall <= ~out_stall;
          stall_run <= $urandom_range(1, 10);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: value %h status %0d empty %b full %b",
                   out_read_value, out_status, out_empty_now, out_full_now);
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value || out_status !== want.status ||
            out_empty_now !== want.empty_now || out_full_now !== want.full_now) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: exp value %h status %0d empty %b full %b,",
                      " got value %h status %0d empty %b full %b"},
                     $realtime, want.read_value, want.status, want.empty_now,
                     want.full_now, out_read_value, out_status, out_empty_now,
                     out_full_now);
        end
      end
    end
  end

  // call at a falling edge; returns at a falling edge after the transfer
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_push_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(deque_step(cmd, val));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    cap_reg = cap;
    front_idx = 0;
    rear_idx = 0;
    fill_count = 0;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_and_unused();
    send_cmd(CMD_PEEK_FRONT, 32'h1234_5678);
    send_cmd(CMD_PEEK_REAR, '0);
    send_cmd(CMD_POP_FRONT, '1);
    send_cmd(CMD_POP_REAR, '0);
    send_cmd(CMD_UNUSED_6, 32'h5555_5555);
    send_cmd(CMD_UNUSED_7, 32'haaaa_aaaa);
  endtask

  // capacity below range clamps to two entries
  task automatic test_two_entry_ring();
    write_capacity(5'd0);
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    send_cmd(CMD_PUSH_REAR, 32'h7fff_ffff);
    send_cmd(CMD_PUSH_FRONT, 32'h0bad_0bad);
    send_cmd(CMD_PEEK_FRONT, '0);
    send_cmd(CMD_PEEK_REAR, '0);
    send_cmd(CMD_UNUSED_7, '1);
    send_cmd(CMD_POP_REAR, '0);
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_POP_FRONT, '0);
  endtask

  // capacity above range clamps to DEPTH; front wraps to the top entry
  task automatic test_front_wrap();
    write_capacity(5'd31);
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0001);
    send_cmd(CMD_PUSH_FRONT, 32'hffff_fffe);
    send_cmd(CMD_PUSH_REAR, 32'h0000_0003);
    send_cmd(CMD_PEEK_FRONT, '0);
    send_cmd(CMD_PEEK_REAR, '0);
    send_cmd(CMD_POP_REAR, '0);
    send_cmd(CMD_POP_FRONT, '0);
  endtask

  task automatic test_random_traffic(input logic [CFG_W-1:0] cap, input int count,
                                     input int stall_sel, input bit gaps);
    logic [CMD_W-1:0] cmd;
    int               push_pct;
    int               run_left;
    int               roll;
    write_capacity(cap);
    stall_mode = stall_sel;
    sender_gaps = gaps;
    burst_left = 0;
    run_left = 0;
    push_pct = 50;
    repeat (count) begin
      if (run_left == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
        run_left = $urandom_range(8, 40);
      end
      run_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3)
        cmd = $urandom_range(0, 1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
      else if (roll < 3 + push_pct)
        cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      else begin
        case ($urandom_range(0, 5))
          0, 1: cmd = CMD_POP_FRONT;
          2, 3: cmd = CMD_POP_REAR;
          4: cmd = CMD_PEEK_FRONT;
          default: cmd = CMD_PEEK_REAR;
        endcase
      end
      send_cmd(cmd, pick_value());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] caps [16];
    caps = '{5'd2, 5'd16, 5'd1, 5'd17, 5'd3, 5'd31, 5'd8, 5'd0,
             5'd5, 5'd15, 5'd12, 5'd4, 5'd16, 5'd2, 5'd9, 5'd30};
    cap_reg = CFG_RESET;
    front_idx = 0;
    rear_idx = 0;
    fill_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_and_unused();
    test_two_entry_ring();
    test_front_wrap();
    for (int ph = 0; ph < 16; ph++)
      test_random_traffic(caps[ph], 110, ph % 3, (ph % 4) != 0);
    for (int ph = 0; ph < 3; ph++)
      test_random_traffic(CFG_W'($urandom_range(0, 31)), 40, 2 - ph, ph != 1);

    wait_idle();
    repeat (4) @(negedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
